### design/msca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msca_pkg
// Shared constants, calibration tables and types of the calibrate/average unit.
// ----------------------------------------------------------------------------
package msca_pkg;

    localparam int unsigned SENSORS   = 3;
    localparam int unsigned POINTS    = 6;
    localparam int unsigned STD_COUNT = 8;
    localparam int unsigned DIV_BITS  = 16;
    // stage A, product stage, one stage per quotient bit, output stage
    localparam int unsigned LANE_LAT  = DIV_BITS + 3;
    localparam int unsigned TOTAL_LAT = LANE_LAT + 3;

    localparam logic [15:0] ERR_LOW  = 16'd0;
    localparam logic [15:0] ERR_HIGH = 16'hFFFF;

    // floor(x / 3) == (x * RECIP3) >> RECIP_SHIFT for every x below 2**23
    localparam logic [21:0] RECIP3      = 22'd2796203;
    localparam int unsigned RECIP_SHIFT = 23;

    localparam logic [2:0] ALERT_NONE   = 3'd0;
    localparam logic [2:0] ALERT_WARMUP = 3'd1;
    localparam logic [2:0] ALERT_FAULT  = 3'd2;
    localparam logic [2:0] ALERT_DARK   = 3'd3;
    localparam logic [2:0] ALERT_BRIGHT = 3'd4;

    localparam logic [1:0] REG_DARK   = 2'd0;
    localparam logic [1:0] REG_BRIGHT = 2'd1;
    localparam logic [1:0] REG_WARMUP = 2'd2;

    // raw points and true values per sensor; true values rise along each table
    localparam logic [15:0] CAL_X [SENSORS][POINTS] = '{
        '{16'd2557, 16'd2930, 16'd3181, 16'd3384, 16'd3649, 16'd4986},
        '{16'd2547, 16'd2914, 16'd3176, 16'd3367, 16'd3628, 16'd5010},
        '{16'd2619, 16'd2919, 16'd3193, 16'd3388, 16'd3658, 16'd4954}
    };
    localparam logic [15:0] CAL_Y [SENSORS][POINTS] = '{
        '{16'd2132, 16'd2719, 16'd3073, 16'd3384, 16'd3875, 16'd5345},
        '{16'd2132, 16'd2719, 16'd3073, 16'd3384, 16'd3875, 16'd5345},
        '{16'd2158, 16'd2719, 16'd3073, 16'd3384, 16'd3875, 16'd5345}
    };

    localparam logic [12:0] STD_TEMP [STD_COUNT] = '{
        13'd2700, 13'd3000, 13'd3500, 13'd4000,
        13'd5000, 13'd5500, 13'd6000, 13'd6500
    };

    typedef struct packed {
        logic [31:0]        rem;
        logic [15:0]        q;
        logic [15:0]        den;
        logic signed [17:0] base;
        logic [15:0]        raw;
        logic [15:0]        lux;
    } div_stage_t;

    typedef struct packed {
        logic        good;
        logic [15:0] corr;
        logic [15:0] lux;
    } lane_out_t;

    typedef struct packed {
        logic [15:0] dark;
        logic [15:0] bright;
    } limits_t;

endpackage

### design/msca_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msca_lane
// One sensor: segment select, product and pipelined restoring divider.
// ----------------------------------------------------------------------------
module msca_lane
    import msca_pkg::*;
#(
    parameter int unsigned LANE = 0
)
(
    input  logic        clk,
    input  logic [15:0] raw,
    input  logic [15:0] lux,
    output lane_out_t   res
);

    logic signed [17:0] base_next;
    logic [15:0]        diff_next;
    logic [15:0]        dy_next;
    logic [15:0]        den_next;
    logic               found;

    logic signed [17:0] sa_base_reg;
    logic [15:0]        sa_diff_reg;
    logic [15:0]        sa_dy_reg;
    logic [15:0]        sa_den_reg;
    logic [15:0]        sa_raw_reg;
    logic [15:0]        sa_lux_reg;

    div_stage_t         pipe_reg [DIV_BITS+1];
    lane_out_t          res_reg;

    logic signed [18:0] sum_v;
    lane_out_t          res_next;

    // pick the segment; ends take the flat offset of the end point
    always_comb
    begin
        base_next = $signed({2'b00, raw});
        diff_next = '0;
        dy_next   = '0;
        den_next  = 16'd1;
        found     = 1'b0;
        if (raw <= CAL_X[LANE][0])
        begin
            base_next = $signed({2'b00, raw}) + $signed({2'b00, CAL_Y[LANE][0]})
                      - $signed({2'b00, CAL_X[LANE][0]});
        end
        else if (raw >= CAL_X[LANE][POINTS-1])
        begin
            base_next = $signed({2'b00, raw}) + $signed({2'b00, CAL_Y[LANE][POINTS-1]})
                      - $signed({2'b00, CAL_X[LANE][POINTS-1]});
        end
        else
        begin
            for (int i = 0; i < POINTS - 1; i++)
            begin
                if (!found && raw >= CAL_X[LANE][i] && raw <= CAL_X[LANE][i+1])
                begin
                    found     = 1'b1;
                    base_next = $signed({2'b00, CAL_Y[LANE][i]});
                    if (CAL_X[LANE][i+1] != CAL_X[LANE][i])
                    begin
                        diff_next = raw - CAL_X[LANE][i];
                        dy_next   = CAL_Y[LANE][i+1] - CAL_Y[LANE][i];
                        den_next  = CAL_X[LANE][i+1] - CAL_X[LANE][i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sa_base_reg <= base_next;
        sa_diff_reg <= diff_next;
        sa_dy_reg   <= dy_next;
        sa_den_reg  <= den_next;
        sa_raw_reg  <= raw;
        sa_lux_reg  <= lux;
        pipe_reg[0] <= '{rem: sa_diff_reg * sa_dy_reg, q: '0, den: sa_den_reg,
                         base: sa_base_reg, raw: sa_raw_reg, lux: sa_lux_reg};
    end

    // one quotient bit per stage, most significant first
    for (genvar g = 0; g < DIV_BITS; g++)
    begin : g_div
        localparam int unsigned B = DIV_BITS - 1 - g;
        logic [31:0] dshift;
        div_stage_t  stage_next;

        always_comb
        begin
            dshift     = 32'(pipe_reg[g].den) << B;
            stage_next = pipe_reg[g];
            if (pipe_reg[g].rem >= dshift)
            begin
                stage_next.rem  = pipe_reg[g].rem - dshift;
                stage_next.q[B] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            pipe_reg[g+1] <= stage_next;
        end
    end

    always_comb
    begin
        sum_v         = 19'(pipe_reg[DIV_BITS].base) + $signed({3'b000, pipe_reg[DIV_BITS].q});
        res_next.lux  = pipe_reg[DIV_BITS].lux;
        res_next.good = pipe_reg[DIV_BITS].raw != ERR_LOW
                     && pipe_reg[DIV_BITS].raw != ERR_HIGH;
        if (!res_next.good)
            res_next.corr = pipe_reg[DIV_BITS].raw;
        else if (sum_v < 0)
            res_next.corr = '0;
        else if (sum_v > 19'sd65535)
            res_next.corr = 16'hFFFF;
        else
            res_next.corr = sum_v[15:0];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

### design/msca_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msca_merge
// Sums, means, nearest standard and alert over the lane results.
// ----------------------------------------------------------------------------
module msca_merge
    import msca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_vld,
    input  logic        in_warm,
    input  lane_out_t   lanes [SENSORS],
    input  limits_t     limits,
    output logic        out_vld,
    output logic [15:0] out_corr [SENSORS],
    output logic [1:0]  out_count,
    output logic [19:0] out_lux,
    output logic [15:0] out_temp,
    output logic [12:0] out_std,
    output logic [2:0]  out_alert
);

    // stage 1
    logic        m1_vld_reg;
    logic        m1_warm_reg, m1_dark_reg, m1_bright_reg;
    logic [1:0]  m1_cnt_reg;
    logic [20:0] m1_lux_reg;
    logic [17:0] m1_temp_reg;
    logic [15:0] m1_corr_reg [SENSORS];
    logic [1:0]  cnt_next;
    logic [20:0] lux_next;
    logic [17:0] temp_next;
    logic        dark_next, bright_next;

    // stage 2
    logic        m2_vld_reg;
    logic        m2_warm_reg, m2_dark_reg, m2_bright_reg;
    logic [1:0]  m2_cnt_reg;
    logic [19:0] m2_lux_reg;
    logic [15:0] m2_temp_reg;
    logic [15:0] m2_corr_reg [SENSORS];
    logic [19:0] mlux_next;
    logic [15:0] mtemp_next;
    logic [43:0] plux, ptemp;

    // stage 3
    logic        vld_reg;
    logic [1:0]  cnt_reg;
    logic [19:0] lux_reg;
    logic [15:0] temp_reg;
    logic [12:0] std_reg;
    logic [2:0]  alert_reg;
    logic [15:0] corr_reg [SENSORS];
    logic [12:0] std_next;
    logic [15:0] best_d, d;
    logic [2:0]  alert_next;

    always_comb
    begin
        cnt_next    = '0;
        lux_next    = '0;
        temp_next   = '0;
        dark_next   = 1'b0;
        bright_next = 1'b0;
        for (int i = 0; i < SENSORS; i++)
        begin
            if (lanes[i].good)
            begin
                cnt_next    = cnt_next + 2'd1;
                lux_next    = lux_next + (21'(lanes[i].lux) << 3) + (21'(lanes[i].lux) << 1);
                temp_next   = temp_next + 18'(lanes[i].corr);
                dark_next   = dark_next | (lanes[i].lux < limits.dark);
                bright_next = bright_next | (lanes[i].lux > limits.bright);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            vld_reg    <= 1'b0;
        end
        else
        begin
            m1_vld_reg <= in_vld;
            m2_vld_reg <= m1_vld_reg;
            vld_reg    <= m2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_warm_reg   <= in_warm;
        m1_dark_reg   <= dark_next;
        m1_bright_reg <= bright_next;
        m1_cnt_reg    <= cnt_next;
        m1_lux_reg    <= lux_next;
        m1_temp_reg   <= temp_next;
        for (int i = 0; i < SENSORS; i++)
            m1_corr_reg[i] <= lanes[i].corr;
    end

    // divide by the count: as is for one, a shift for two, reciprocal multiply for three; zero for none
    assign plux  = 44'(m1_lux_reg) * 44'(RECIP3);
    assign ptemp = 44'(m1_temp_reg) * 44'(RECIP3);

    always_comb
    begin
        unique case (m1_cnt_reg)
            2'd0:
            begin
                mlux_next  = '0;
                mtemp_next = '0;
            end
            2'd1:
            begin
                mlux_next  = m1_lux_reg[19:0];
                mtemp_next = m1_temp_reg[15:0];
            end
            2'd2:
            begin
                mlux_next  = m1_lux_reg[20:1];
                mtemp_next = m1_temp_reg[16:1];
            end
            default:
            begin
                mlux_next  = plux[RECIP_SHIFT +: 20];
                mtemp_next = ptemp[RECIP_SHIFT +: 16];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        m2_warm_reg   <= m1_warm_reg;
        m2_dark_reg   <= m1_dark_reg;
        m2_bright_reg <= m1_bright_reg;
        m2_cnt_reg    <= m1_cnt_reg;
        m2_lux_reg    <= mlux_next;
        m2_temp_reg   <= mtemp_next;
        m2_corr_reg   <= m1_corr_reg;
    end

    // strict compare keeps the lower standard on a tie
    always_comb
    begin
        std_next = STD_TEMP[0];
        best_d   = (m2_temp_reg > 16'(STD_TEMP[0])) ? m2_temp_reg - 16'(STD_TEMP[0])
                                                    : 16'(STD_TEMP[0]) - m2_temp_reg;
        d        = '0;
        for (int i = 1; i < STD_COUNT; i++)
        begin
            d = (m2_temp_reg > 16'(STD_TEMP[i])) ? m2_temp_reg - 16'(STD_TEMP[i])
                                                 : 16'(STD_TEMP[i]) - m2_temp_reg;
            if (d < best_d)
            begin
                best_d   = d;
                std_next = STD_TEMP[i];
            end
        end
        if (m2_temp_reg == ERR_LOW || m2_temp_reg == ERR_HIGH)
            std_next = '0;

        priority if (m2_warm_reg)
            alert_next = ALERT_WARMUP;
        else if (m2_cnt_reg == 2'd0 || m2_temp_reg == '0)
            alert_next = ALERT_FAULT;
        else if (m2_dark_reg)
            alert_next = ALERT_DARK;
        else if (m2_bright_reg)
            alert_next = ALERT_BRIGHT;
        else
            alert_next = ALERT_NONE;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= m2_cnt_reg;
        lux_reg   <= m2_lux_reg;
        temp_reg  <= m2_temp_reg;
        std_reg   <= std_next;
        alert_reg <= alert_next;
        corr_reg  <= m2_corr_reg;
    end

    assign out_vld   = vld_reg;
    assign out_corr  = corr_reg;
    assign out_count = cnt_reg;
    assign out_lux   = lux_reg;
    assign out_temp  = temp_reg;
    assign out_std   = std_reg;
    assign out_alert = alert_reg;

endmodule

### design/multi_sensor_cct_calibrate_average_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_sensor_cct_calibrate_average_unit
// Three-sensor colour temperature calibration, averaging and alert unit.
// ----------------------------------------------------------------------------
// An item is taken on every cycle with start high (busy is never raised). Its
// result is strobed on done after the lane and merge registers, one result per
// item, in order. Each sensor lane holds a segment select, a product stage, 16
// divider stages resolving one quotient bit each, and a lane output register.
// Three merge stages follow.
// The receiver cannot stall; results must be taken on the strobe cycle.
// ----------------------------------------------------------------------------
module multi_sensor_cct_calibrate_average_unit
    import msca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [31:0] wr_data,
    input  logic [15:0] lux_first,
    input  logic [15:0] lux_second,
    input  logic [15:0] lux_third,
    input  logic [15:0] raw_temp_first,
    input  logic [15:0] raw_temp_second,
    input  logic [15:0] raw_temp_third,
    input  logic [31:0] elapsed_ms,
    output logic [15:0] corr_temp_first,
    output logic [15:0] corr_temp_second,
    output logic [15:0] corr_temp_third,
    output logic [1:0]  good_sensors,
    output logic [19:0] mean_lux_tenths,
    output logic [15:0] mean_temp,
    output logic [12:0] nearest_standard,
    output logic [2:0]  alert_code
);

    logic [15:0] dark_reg, bright_reg;
    logic [31:0] warmup_reg;
    logic        vld_pipe_reg  [LANE_LAT];
    logic        warm_pipe_reg [LANE_LAT];
    logic [15:0] raw_in [SENSORS];
    logic [15:0] lux_in [SENSORS];
    lane_out_t   lanes  [SENSORS];
    logic [15:0] corr   [SENSORS];
    limits_t     limits;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_reg   <= 16'd500;
            bright_reg <= 16'd10000;
            warmup_reg <= 32'd20000;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_DARK:   dark_reg   <= wr_data[15:0];
                REG_BRIGHT: bright_reg <= wr_data[15:0];
                REG_WARMUP: warmup_reg <= wr_data;
                default:    ;
            endcase
        end
    end

    // carry item valid and the warm-up flag alongside the lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_LAT; i++)
                vld_pipe_reg[i] <= 1'b0;
        end
        else
        begin
            vld_pipe_reg[0] <= start && !busy;
            for (int i = 1; i < LANE_LAT; i++)
                vld_pipe_reg[i] <= vld_pipe_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        warm_pipe_reg[0] <= elapsed_ms < warmup_reg;
        for (int i = 1; i < LANE_LAT; i++)
            warm_pipe_reg[i] <= warm_pipe_reg[i-1];
    end

    assign raw_in = '{raw_temp_first, raw_temp_second, raw_temp_third};
    assign lux_in = '{lux_first, lux_second, lux_third};

    for (genvar g = 0; g < SENSORS; g++)
    begin : g_lane
        msca_lane #(.LANE(g)) u_lane
        (
            .clk (clk),
            .raw (raw_in[g]),
            .lux (lux_in[g]),
            .res (lanes[g])
        );
    end

    assign limits = '{dark: dark_reg, bright: bright_reg};

    msca_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (vld_pipe_reg[LANE_LAT-1]),
        .in_warm   (warm_pipe_reg[LANE_LAT-1]),
        .lanes     (lanes),
        .limits    (limits),
        .out_vld   (done),
        .out_corr  (corr),
        .out_count (good_sensors),
        .out_lux   (mean_lux_tenths),
        .out_temp  (mean_temp),
        .out_std   (nearest_standard),
        .out_alert (alert_code)
    );

    assign corr_temp_first  = corr[0];
    assign corr_temp_second = corr[1];
    assign corr_temp_third  = corr[2];

endmodule

### design/msca_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msca_checker
// Port-level checks of the calibrate/average unit, bound to the top level.
// ----------------------------------------------------------------------------
module msca_checker
    import msca_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  good_sensors,
    input logic [15:0] mean_temp,
    input logic [12:0] nearest_standard,
    input logic [2:0]  alert_code
);

    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, TOTAL_LAT))
        else $error("result without an item taken");

    a_none_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done && good_sensors == 2'd0 |-> mean_temp == '0 && nearest_standard == '0)
        else $error("mean reported with no valid sensor");

    a_fault: assert property (@(posedge clk) disable iff (!rst_n)
        done && alert_code != ALERT_WARMUP && mean_temp == '0 |-> alert_code == ALERT_FAULT)
        else $error("zero mean not flagged as fault");

endmodule

bind multi_sensor_cct_calibrate_average_unit msca_checker u_msca_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .good_sensors     (good_sensors),
    .mean_temp        (mean_temp),
    .nearest_standard (nearest_standard),
    .alert_code       (alert_code)
);

### bench/multi_sensor_cct_calibrate_average_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_sensor_cct_calibrate_average_unit_tb
// Self-checking bench for the three-sensor calibrate/average unit. Items of
// readings are issued in a directed run and in random bursts; a scoreboard predicts each result
// from the calibration tables and compares every strobed result in order.
// ----------------------------------------------------------------------------
module multi_sensor_cct_calibrate_average_unit_tb;
    import msca_pkg::*;

    typedef struct {
        logic [15:0] lux [3];
        logic [15:0] raw [3];
        logic [31:0] elapsed;
    } round_t;

    typedef struct {
        logic [15:0] corr [3];
        logic [1:0]  good;
        logic [19:0] mlux;
        logic [15:0] mtemp;
        logic [12:0] nstd;
        logic [2:0]  alert;
    } summary_t;

    class cct_scoreboard;
        summary_t    pending [$];
        logic [15:0] dark_lim;
        logic [15:0] bright_lim;
        logic [31:0] warmup;
        int          errors;

        function new();
            dark_lim = 16'd500;
            bright_lim = 16'd10000;
            warmup = 32'd20000;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] d);
            if (idx == REG_DARK) dark_lim = d[15:0];
            else if (idx == REG_BRIGHT) bright_lim = d[15:0];
            else if (idx == REG_WARMUP) warmup = d;
        endfunction

        function logic [15:0] calibrate(int s, logic [15:0] raw);
            longint r, v, xa, xb, ya, yb, num;
            r = raw;
            v = r;
            if (r <= CAL_X[s][0]) v = r + CAL_Y[s][0] - CAL_X[s][0];
            else if (r >= CAL_X[s][POINTS-1])
                v = r + CAL_Y[s][POINTS-1] - CAL_X[s][POINTS-1];
            else
            begin
                for (int i = 0; i < POINTS - 1; i++)
                begin
                    xa = CAL_X[s][i]; xb = CAL_X[s][i+1];
                    if (r >= xa && r <= xb)
                    begin
                        ya = CAL_Y[s][i]; yb = CAL_Y[s][i+1];
                        if (xb - xa <= 0) v = ya;
                        else
                        begin
                            num = ya * (xb - xa) + (r - xa) * (yb - ya);
                            v = (num < 0) ? -1 : num / (xb - xa);
                        end
                        break;
                    end
                end
            end
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            return v[15:0];
        endfunction

        function void note_round(round_t rd);
            summary_t e;
            longint lsum, tsum, bd, d;
            int n;
            bit dk, br;
            lsum = 0; tsum = 0; n = 0; dk = 0; br = 0;
            for (int s = 0; s < 3; s++)
            begin
                e.corr[s] = rd.raw[s];
                if (rd.raw[s] != ERR_LOW && rd.raw[s] != ERR_HIGH)
                begin
                    e.corr[s] = calibrate(s, rd.raw[s]);
                    lsum += rd.lux[s];
                    tsum += e.corr[s];
                    n++;
                    if (rd.lux[s] < dark_lim) dk = 1;
                    if (rd.lux[s] > bright_lim) br = 1;
                end
            end
            e.good = 2'(n);
            e.mlux = (n > 0) ? 20'((lsum * 10) / n) : '0;
            e.mtemp = (n > 0) ? 16'(tsum / n) : '0;
            e.nstd = '0;
            if (e.mtemp != ERR_LOW && e.mtemp != ERR_HIGH)
            begin
                e.nstd = STD_TEMP[0];
                bd = e.mtemp - longint'(STD_TEMP[0]);
                if (bd < 0) bd = -bd;
                for (int i = 1; i < STD_COUNT; i++)
                begin
                    d = e.mtemp - longint'(STD_TEMP[i]);
                    if (d < 0) d = -d;
                    if (d < bd)
                    begin
                        bd = d;
                        e.nstd = STD_TEMP[i];
                    end
                end
            end
            if (rd.elapsed < warmup) e.alert = ALERT_WARMUP;
            else if (n == 0 || e.mtemp == 0) e.alert = ALERT_FAULT;
            else if (dk) e.alert = ALERT_DARK;
            else if (br) e.alert = ALERT_BRIGHT;
            else e.alert = ALERT_NONE;
            pending.push_back(e);
        endfunction

        function void check_result(summary_t got);
            summary_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result at %0t", $time);
                return;
            end
            e = pending.pop_front();
            if (got.corr != e.corr || got.good != e.good || got.mlux != e.mlux ||
                got.mtemp != e.mtemp || got.nstd != e.nstd || got.alert != e.alert)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("result %0t: exp %0d %0d %0d g%0d l%0d t%0d s%0d a%0d",
                        $time, e.corr[0], e.corr[1], e.corr[2], e.good, e.mlux,
                        e.mtemp, e.nstd, e.alert);
                    $display("    got %0d %0d %0d g%0d l%0d t%0d s%0d a%0d",
                        got.corr[0], got.corr[1], got.corr[2], got.good, got.mlux,
                        got.mtemp, got.nstd, got.alert);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    logic        wr_en;
    logic [1:0]  wr_index;
    logic [31:0] wr_data;
    logic [15:0] lux_first, lux_second, lux_third;
    logic [15:0] raw_temp_first, raw_temp_second, raw_temp_third;
    logic [31:0] elapsed_ms;
    logic [15:0] corr_temp_first, corr_temp_second, corr_temp_third;
    logic [1:0]  good_sensors;
    logic [19:0] mean_lux_tenths;
    logic [15:0] mean_temp;
    logic [12:0] nearest_standard;
    logic [2:0]  alert_code;

    cct_scoreboard board;

    multi_sensor_cct_calibrate_average_unit DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("multi_sensor_cct_calibrate_average_unit: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        summary_t got;
        if (rst_n && done)
        begin
            got.corr[0] = corr_temp_first;
            got.corr[1] = corr_temp_second;
            got.corr[2] = corr_temp_third;
            got.good = good_sensors;
            got.mlux = mean_lux_tenths;
            got.mtemp = mean_temp;
            got.nstd = nearest_standard;
            got.alert = alert_code;
            board.check_result(got);
        end
    end

    // Offer one item and hold it until accepted; start stays high for bursts.
    task automatic issue_round(round_t rd, bit keep);
        start <= 1'b1;
        lux_first <= rd.lux[0]; lux_second <= rd.lux[1]; lux_third <= rd.lux[2];
        raw_temp_first <= rd.raw[0]; raw_temp_second <= rd.raw[1];
        raw_temp_third <= rd.raw[2];
        elapsed_ms <= rd.elapsed;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_round(rd);
        if (!keep) start <= 1'b0;
    endtask

    // Return the enable low after each write so writes never overlap.
    task automatic write_reg(logic [1:0] idx, logic [31:0] d);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= d;
        @(posedge clk);
        wr_en <= 1'b0;
        board.set_reg(idx, d);
        @(posedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (board.pending.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (TOTAL_LAT + 4) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_raw(int s);
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return ERR_LOW;
        if (k == 1) return ERR_HIGH;
        if (k < 5) return 16'($urandom_range(0, 65535));
        if (k < 8)
            return 16'(CAL_X[s][$urandom_range(0, POINTS - 1)] + $urandom_range(0, 2) - 1);
        return 16'($urandom_range(2400, 5200));
    endfunction

    function automatic logic [15:0] pick_lux();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 16'd0;
        if (k == 1) return 16'hFFFF;
        if (k < 5) return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(200, 12000));
    endfunction

    function automatic round_t random_round();
        round_t rd;
        for (int s = 0; s < 3; s++)
        begin
            rd.lux[s] = pick_lux();
            rd.raw[s] = pick_raw(s);
        end
        case ($urandom_range(0, 5))
            0: rd.elapsed = $urandom();
            1: rd.elapsed = $urandom_range(0, 40000);
            2: rd.elapsed = 32'hFFFFFFFF;
            default: rd.elapsed = $urandom_range(20000, 10000000);
        endcase
        return rd;
    endfunction

    // Keep start high across a burst boundary when no gap follows.
    task automatic random_phase(int count);
        int left, burst, gap;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            if (burst > left) burst = left;
            gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 30) : 0;
            for (int i = 0; i < burst; i++)
                issue_round(random_round(), i != burst - 1 || (gap == 0 && left > burst));
            left -= burst;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        round_t rd;
        board = new();
        rst_n = 1'b0;
        start = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        lux_first = '0; lux_second = '0; lux_third = '0;
        raw_temp_first = '0; raw_temp_second = '0; raw_temp_third = '0;
        elapsed_ms = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: error codes, table edges, extremes, each alert
        rd.elapsed = 32'd30000;
        for (int s = 0; s < 3; s++) rd.lux[s] = 16'd1000;
        for (int p = 0; p < POINTS; p++)
        begin
            for (int s = 0; s < 3; s++) rd.raw[s] = CAL_X[s][p];
            issue_round(rd, 1);
        end
        rd.raw = '{16'd1, 16'd2, 16'hFFFE}; issue_round(rd, 1);
        rd.raw = '{ERR_LOW, ERR_HIGH, ERR_LOW}; issue_round(rd, 1);
        rd.raw = '{ERR_LOW, 16'd3000, ERR_HIGH}; issue_round(rd, 1);
        rd.raw = '{16'd100, 16'd100, 16'd100}; issue_round(rd, 1);
        rd.raw = '{16'd3250, 16'd3250, 16'd3250}; issue_round(rd, 1);
        rd.raw = '{16'd3600, 16'd3600, 16'd3600}; issue_round(rd, 1);
        rd.lux = '{16'd0, 16'd600, 16'hFFFF}; issue_round(rd, 1);
        rd.lux = '{16'd20000, 16'd600, 16'hFFFF}; issue_round(rd, 1);
        rd.lux = '{16'hFFFF, 16'hFFFF, 16'hFFFF}; issue_round(rd, 1);
        rd.elapsed = 32'd0; issue_round(rd, 1);
        rd.elapsed = 32'd19999; issue_round(rd, 1);
        rd.elapsed = 32'hFFFFFFFF; issue_round(rd, 0);
        drain();

        random_phase(400);
        drain();
        write_reg(REG_DARK, 32'd0);
        write_reg(REG_BRIGHT, 32'h0000FFFF);
        write_reg(REG_WARMUP, 32'd0);
        random_phase(400);
        drain();
        write_reg(REG_DARK, 32'h0000FFFF);
        write_reg(REG_BRIGHT, 32'd0);
        write_reg(REG_WARMUP, 32'hFFFFFFFF);
        random_phase(200);
        drain();
        write_reg(REG_DARK, $urandom_range(0, 65535));
        write_reg(REG_BRIGHT, $urandom_range(0, 65535));
        write_reg(REG_WARMUP, $urandom());
        write_reg(2'd3, $urandom());
        random_phase(500);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("multi_sensor_cct_calibrate_average_unit: match");
        else
            $display("multi_sensor_cct_calibrate_average_unit: mismatch");
        $finish;
    end

endmodule

### sim.f
design/msca_pkg.sv
design/msca_lane.sv
design/msca_merge.sv
design/multi_sensor_cct_calibrate_average_unit.sv
design/msca_checker.sv
bench/multi_sensor_cct_calibrate_average_unit_tb.sv
